// ----- design/dlpa_pkg.sv -----
// Shared types, codes and constants for the DHCP lease pool allocator.
// Used by the front, queue, back and top level; the RAM does not use it. Depends on nothing.
package dlpa_pkg;

  // Field widths of the words on either side
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CLIENT_W = 16;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned EXP_W    = 33;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned SIZE_W   = 11;

  // Default pool depth and register reset values
  localparam int unsigned POOL_DEPTH_DEF    = 1024;
  localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 11'd1024;
  localparam logic [TIME_W-1:0] DEF_LEASE_RST = 32'd3600;
  localparam logic [TIME_W-1:0] MAX_LEASE_RST = 32'd86400;
  localparam logic [TIME_W-1:0] MIN_LEASE_RST = 32'd60;

  // Configuration register indexes
  localparam logic [1:0] CFG_POOL_SIZE = 2'd0;
  localparam logic [1:0] CFG_DEF_LEASE = 2'd1;
  localparam logic [1:0] CFG_MAX_LEASE = 2'd2;
  localparam logic [1:0] CFG_MIN_LEASE = 2'd3;

  // Message types and receivers
  localparam logic [CODE_W-1:0] MODE_DISCOVER = 2'd0;
  localparam logic [CODE_W-1:0] MODE_REQUEST  = 2'd1;
  localparam logic [CODE_W-1:0] TGT_BCAST     = 2'd0;
  localparam logic [CODE_W-1:0] TGT_HERE      = 2'd1;
  localparam logic [CODE_W-1:0] TGT_OTHER     = 2'd2;

  // Per-address lease states
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_OFFER = 2'd1;
  localparam logic [1:0] ST_OCC   = 2'd2;
  localparam logic [1:0] ST_EXP   = 2'd3;

  // Reply kinds
  localparam logic [CODE_W-1:0] KIND_OFFER = 2'd0;
  localparam logic [CODE_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [CODE_W-1:0] KIND_NAK   = 2'd2;

  // Width of one pool entry: state, owner, expiry
  localparam int unsigned ENTRY_W = 2 + CLIENT_W + EXP_W;

  // Operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_DISCOVER,
    OP_REQ_HERE,
    OP_REQ_OTHER
  } op_t;

  // One classified message as it waits in the queue
  typedef struct packed {
    op_t                 op;
    logic [TIME_W-1:0]   now;
    logic [CLIENT_W-1:0] client;
    logic [ADDR_W-1:0]   req_addr;
    logic [TIME_W-1:0]   want;
    logic [TIME_W-1:0]   lease_add;
    logic                use_want;
  } item_t;

  // Status of the back end seen by the front and the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

endpackage

// ----- design/dlpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the pool table.
module dlpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/dlpa_front.sv -----
// Front end: accepts message words, drops unhandled kinds and picks the lease term.
// Depends on dlpa_pkg.
module dlpa_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [95:0]                    s_tdata,
  input  logic [3:0]                     s_tuser,
  input  logic [dlpa_pkg::TIME_W-1:0]    default_lease,
  input  logic [dlpa_pkg::TIME_W-1:0]    max_lease,
  input  logic [dlpa_pkg::TIME_W-1:0]    min_lease,
  input  dlpa_pkg::back_status_t         bstat,
  input  logic                           q_ready,
  output logic                           q_push,
  output dlpa_pkg::item_t                q_item
);

  logic [dlpa_pkg::TIME_W-1:0]   now;
  logic [dlpa_pkg::CLIENT_W-1:0] client;
  logic [dlpa_pkg::ADDR_W-1:0]   req_addr;
  logic [dlpa_pkg::TIME_W-1:0]   want;
  logic [dlpa_pkg::CODE_W-1:0]   mode;
  logic [dlpa_pkg::CODE_W-1:0]   target;
  logic                          handled;
  dlpa_pkg::op_t                 op;
  logic [dlpa_pkg::TIME_W:0]     diff;
  logic                          neg;
  logic                          gt_max;
  logic                          lt_min;

  assign now      = s_tdata[31:0];
  assign client   = s_tdata[47:32];
  assign req_addr = s_tdata[63:48];
  assign want     = s_tdata[95:64];
  assign mode     = s_tuser[1:0];
  assign target   = s_tuser[3:2];

  // No word is taken while the pool is being cleared or the queue is full.
  assign s_tready = q_ready && !bstat.clearing;

  // Classify the message.
  always_comb begin
    handled = 1'b1;
    op      = dlpa_pkg::OP_DISCOVER;
    if (mode == dlpa_pkg::MODE_DISCOVER && target == dlpa_pkg::TGT_BCAST) begin
      op = dlpa_pkg::OP_DISCOVER;
    end else if (mode == dlpa_pkg::MODE_REQUEST && target == dlpa_pkg::TGT_HERE) begin
      op = dlpa_pkg::OP_REQ_HERE;
    end else if (mode == dlpa_pkg::MODE_REQUEST && target == dlpa_pkg::TGT_OTHER) begin
      op = dlpa_pkg::OP_REQ_OTHER;
    end else begin
      handled = 1'b0;
    end
  end

  // Lease term: an in-bounds request keeps its end time; else default, max or min.
  assign diff   = {1'b0, want} - {1'b0, now};
  assign neg    = diff[dlpa_pkg::TIME_W];
  assign gt_max = !neg && (diff[dlpa_pkg::TIME_W-1:0] > max_lease);
  assign lt_min = neg || (diff[dlpa_pkg::TIME_W-1:0] < min_lease);

  always_comb begin
    q_item.op       = op;
    q_item.now      = now;
    q_item.client   = client;
    q_item.req_addr = req_addr;
    q_item.want     = want;
    q_item.use_want = (want != '0) && !gt_max && !lt_min;
    if (want == '0) begin
      q_item.lease_add = default_lease;
    end else if (gt_max) begin
      q_item.lease_add = max_lease;
    end else begin
      q_item.lease_add = min_lease;
    end
  end

  assign q_push = s_tvalid && s_tready && handled;

endmodule

// ----- design/dlpa_queue.sv -----
// Two-entry queue of classified messages between the front and the back.
// Depends on dlpa_pkg.
module dlpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dlpa_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output dlpa_pkg::item_t head,
  output logic [1:0]      count
);

  dlpa_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/dlpa_back.sv -----
// Back end: clears the pool after reset, then runs one scan pass per message
// that expires leases and finds the address, then commits and, where one is due, replies.
// Depends on dlpa_pkg and dlpa_ram.
module dlpa_back #(
  parameter int unsigned POOL_DEPTH = dlpa_pkg::POOL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dlpa_pkg::SIZE_W-1:0]    pool_size,
  input  logic                           q_valid,
  input  dlpa_pkg::item_t                q_head,
  output logic                           q_pop,
  output dlpa_pkg::back_status_t         bstat,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [71:0]                    m_tdata,
  output logic [1:0]                     m_tuser
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = dlpa_pkg::EXP_W;
  localparam int unsigned OW = dlpa_pkg::CLIENT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   clr_cnt;
  logic [CW-1:0]                   iss_cnt;
  logic                            pvld;
  logic [AW-1:0]                   pidx;
  dlpa_pkg::item_t                 cur;
  logic [EW-1:0]                   new_exp;
  logic                            f_own, f_free, f_exp, f_hit;
  logic [AW-1:0]                   i_own, i_free, i_exp, i_hit;
  logic                            out_valid;
  logic [dlpa_pkg::CODE_W-1:0]     out_kind;
  logic [dlpa_pkg::CLIENT_W-1:0]   out_client;
  logic [dlpa_pkg::ADDR_W-1:0]     out_addr;
  logic [EW-1:0]                   out_exp;

  logic [CW-1:0]                   size;
  logic                            issue;
  logic                            last;
  logic                            can_out;
  logic                            has_reply;
  logic                            disc_found;
  logic [AW-1:0]                   pick;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [dlpa_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [dlpa_pkg::ENTRY_W-1:0]    ram_rdata;

  logic [1:0]                      rd_st;
  logic [OW-1:0]                   rd_own;
  logic [EW-1:0]                   rd_exp;
  logic [1:0]                      sw_st;
  logic [OW-1:0]                   sw_own;
  logic [EW-1:0]                   sw_exp;
  logic                            mine;

  // Active pool size, limited to the table depth
  assign size = (32'(pool_size) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(pool_size);

  assign issue = (state == S_SCAN) && (iss_cnt < size);
  assign last  = pvld && (CW'(pidx) == size - CW'(1));

  // Entry read back from the table, then aged and released
  assign rd_st  = ram_rdata[dlpa_pkg::ENTRY_W-1 -: 2];
  assign rd_own = ram_rdata[EW +: OW];
  assign rd_exp = ram_rdata[EW-1:0];
  assign mine   = (sw_own == cur.client);

  always_comb begin
    sw_st  = rd_st;
    sw_own = rd_own;
    sw_exp = rd_exp;
    if (rd_exp <= EW'(cur.now)) begin
      if (rd_st == dlpa_pkg::ST_OFFER) begin
        sw_st  = dlpa_pkg::ST_FREE;
        sw_own = '0;
        sw_exp = '0;
      end else if (rd_st == dlpa_pkg::ST_OCC) begin
        sw_st  = dlpa_pkg::ST_EXP;
        sw_exp = '0;
      end
    end
    if (cur.op == dlpa_pkg::OP_REQ_OTHER && sw_st == dlpa_pkg::ST_OFFER &&
        sw_own == cur.client) begin
      sw_st  = dlpa_pkg::ST_FREE;
      sw_own = '0;
      sw_exp = '0;
    end
  end

  // Discover choice: own address, then free, then expired
  always_comb begin
    disc_found = f_own || f_free || f_exp;
    if (f_own) begin
      pick = i_own;
    end else if (f_free) begin
      pick = i_free;
    end else begin
      pick = i_exp;
    end
  end

  assign has_reply = (cur.op == dlpa_pkg::OP_REQ_HERE) ||
                     (cur.op == dlpa_pkg::OP_DISCOVER && disc_found);
  assign can_out   = !out_valid || m_tready;

  // Table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = {sw_st, sw_own, sw_exp};
    ram_raddr = iss_cnt[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_SCAN: begin
        ram_we = pvld;
      end
      S_DONE: begin
        if (can_out) begin
          if (cur.op == dlpa_pkg::OP_DISCOVER && disc_found) begin
            ram_we    = 1'b1;
            ram_waddr = pick;
            ram_wdata = {dlpa_pkg::ST_OFFER, cur.client, new_exp};
          end else if (cur.op == dlpa_pkg::OP_REQ_HERE && f_hit) begin
            ram_we    = 1'b1;
            ram_waddr = i_hit;
            ram_wdata = {dlpa_pkg::ST_OCC, cur.client, new_exp};
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Sequencer with registered reply
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      iss_cnt   <= '0;
      pvld      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      pvld <= issue;
      if (issue) begin
        pidx    <= iss_cnt[AW-1:0];
        iss_cnt <= iss_cnt + CW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(POOL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_head;
            new_exp <= q_head.use_want ? EW'(q_head.want) :
                       EW'(q_head.now) + EW'(q_head.lease_add);
            iss_cnt <= '0;
            f_own   <= 1'b0;
            f_free  <= 1'b0;
            f_exp   <= 1'b0;
            f_hit   <= 1'b0;
            state   <= (size == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (pvld) begin
            if (!f_own && sw_st != dlpa_pkg::ST_FREE && mine) begin
              f_own <= 1'b1;
              i_own <= pidx;
            end
            if (!f_free && sw_st == dlpa_pkg::ST_FREE) begin
              f_free <= 1'b1;
              i_free <= pidx;
            end
            if (!f_exp && sw_st == dlpa_pkg::ST_EXP) begin
              f_exp <= 1'b1;
              i_exp <= pidx;
            end
            if ({1'b0, cur.req_addr} == 17'(pidx) + 17'd1 &&
                sw_st != dlpa_pkg::ST_FREE && mine) begin
              f_hit <= 1'b1;
              i_hit <= pidx;
            end
          end
          if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!has_reply) begin
            state <= S_IDLE;
          end else if (can_out) begin
            out_valid  <= 1'b1;
            out_client <= cur.client;
            state      <= S_IDLE;
            if (cur.op == dlpa_pkg::OP_DISCOVER) begin
              out_kind <= dlpa_pkg::KIND_OFFER;
              out_addr <= dlpa_pkg::ADDR_W'(32'(pick) + 32'd1);
              out_exp  <= new_exp;
            end else if (f_hit) begin
              out_kind <= dlpa_pkg::KIND_ACK;
              out_addr <= cur.req_addr;
              out_exp  <= new_exp;
            end else begin
              out_kind <= dlpa_pkg::KIND_NAK;
              out_addr <= cur.req_addr;
              out_exp  <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign bstat.clearing = (state == S_CLEAR);
  assign bstat.busy     = (state != S_IDLE);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {7'd0, out_exp, out_addr, out_client};

  // Pool table: state, owner, expiry per address
  dlpa_ram #(
    .WIDTH (dlpa_pkg::ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- design/dhcp_lease_pool_allocator_top.sv -----
// DHCP lease pool allocator, top level: configuration registers, front, queue, back.
// Each handled message holds the back while it is taken from the queue, while a scan
// pass runs over the active pool (one read and one write port, one entry per cycle; no
// pass when the pool size is zero) and while it commits. The back takes no new message
// before it is through with the last, and a commit with a reply waits while the
// previous reply is not yet taken; ignored messages never reach the back.
// After reset the pool table is cleared; no word is taken then.
// Depends on dlpa_pkg, dlpa_front, dlpa_queue, dlpa_back and dlpa_ram.
module dhcp_lease_pool_allocator_top #(
  parameter int unsigned POOL_DEPTH = dlpa_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // Message words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // now, client_id, req_addr, req_expiry
  input  logic [3:0]  s_tuser,   // mode, target
  // Reply words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // reply_client, reply_addr, reply_expiry, zero fill
  output logic [1:0]  m_tuser    // reply_kind
);

  logic [dlpa_pkg::SIZE_W-1:0] pool_size;
  logic [dlpa_pkg::TIME_W-1:0] default_lease;
  logic [dlpa_pkg::TIME_W-1:0] max_lease;
  logic [dlpa_pkg::TIME_W-1:0] min_lease;

  dlpa_pkg::back_status_t bstat;
  dlpa_pkg::item_t        push_item;
  dlpa_pkg::item_t        head;
  logic                   q_push;
  logic                   q_ready;
  logic                   q_pop;
  logic                   q_valid;
  logic [1:0]             q_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size     <= dlpa_pkg::POOL_SIZE_RST;
      default_lease <= dlpa_pkg::DEF_LEASE_RST;
      max_lease     <= dlpa_pkg::MAX_LEASE_RST;
      min_lease     <= dlpa_pkg::MIN_LEASE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dlpa_pkg::CFG_POOL_SIZE: pool_size     <= cfg_wdata[dlpa_pkg::SIZE_W-1:0];
        dlpa_pkg::CFG_DEF_LEASE: default_lease <= cfg_wdata;
        dlpa_pkg::CFG_MAX_LEASE: max_lease     <= cfg_wdata;
        default:                 min_lease     <= cfg_wdata;
      endcase
    end
  end

  dlpa_front u_front (
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .default_lease (default_lease),
    .max_lease     (max_lease),
    .min_lease     (min_lease),
    .bstat         (bstat),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  dlpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head),
    .count     (q_count)
  );

  dlpa_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pool_size (pool_size),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .bstat     (bstat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef ASSERT_OFF
  // No message enters while the pool table is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !s_tready)
    else $error("message accepted during pool clear");

  // The queue is never pushed while full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != 2'd2))
    else $error("queue overflow");

  // A refusal always carries a zero expiry.
  a_nak_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dlpa_pkg::KIND_NAK) |-> (m_tdata[64:32] == '0))
    else $error("refusal with non-zero expiry");

  // No reply is pending while the pool clear is still running.
  a_no_reply_clear: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !m_tvalid)
    else $error("reply during pool clear");
`endif

endmodule

// ----- tb/dhcp_lease_pool_allocator_top_test.sv -----
// Testbench for the DHCP lease pool allocator top level: directed and random messages,
// predicted replies checked word by word. Depends on dlpa_pkg and dhcp_lease_pool_allocator_top.
module dhcp_lease_pool_allocator_top_test;

  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 16000;
  localparam int DRAIN_CYCLES = 3200;

  typedef struct {
    logic [dlpa_pkg::CODE_W-1:0]   kind;
    logic [dlpa_pkg::CLIENT_W-1:0] client;
    logic [dlpa_pkg::ADDR_W-1:0]   addr;
    logic [dlpa_pkg::EXP_W-1:0]    expiry;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = dlpa_pkg::CFG_POOL_SIZE;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // now, client_id, req_addr, req_expiry
  logic [3:0]  s_tuser = '0;   // mode, target
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // reply_client, reply_addr, reply_expiry, zero fill
  logic [1:0]  m_tuser;        // reply_kind

  // Mirror of the pool and of the registers
  logic [1:0]                    lease_st [DEPTH];
  logic [dlpa_pkg::CLIENT_W-1:0] lease_owner [DEPTH];
  logic [dlpa_pkg::EXP_W-1:0]    lease_exp [DEPTH];
  logic [dlpa_pkg::SIZE_W-1:0]   pool_size_reg = dlpa_pkg::POOL_SIZE_RST;
  logic [31:0]                   def_lease_reg = dlpa_pkg::DEF_LEASE_RST;
  logic [31:0]                   max_lease_reg = dlpa_pkg::MAX_LEASE_RST;
  logic [31:0]                   min_lease_reg = dlpa_pkg::MIN_LEASE_RST;
  logic [dlpa_pkg::ADDR_W-1:0]   last_offer [logic [dlpa_pkg::CLIENT_W-1:0]];

  reply_t      replies_due[$];
  logic [99:0] msgs_pending[$];   // user over data
  int          msgs_queued = 0;
  int          msgs_taken = 0;
  int          errors = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          gaps_on = 1'b1;
  int          idle_cycles = 0;
  logic [31:0] clock_now = '0;

  dhcp_lease_pool_allocator_top DUT (.*);

  always #2 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic logic [dlpa_pkg::EXP_W-1:0] lease_end(input logic [31:0] now,
                                                          input logic [31:0] want);
    longint d;
    if (want == 0) return {1'b0, now} + {1'b0, def_lease_reg};
    d = longint'(want) - longint'(now);
    if (d > longint'(max_lease_reg)) d = longint'(max_lease_reg);
    else if (d < longint'(min_lease_reg)) d = longint'(min_lease_reg);
    return dlpa_pkg::EXP_W'(longint'(now) + d);
  endfunction

  // Apply one accepted message to the mirror and queue its reply, if any.
  function automatic void serve_message(input logic [99:0] w);
    logic [31:0] now;
    logic [15:0] cl, ra;
    logic [31:0] want;
    logic [1:0]  mode, tgt;
    int          size, pick;
    reply_t      r;
    now = w[31:0];
    cl = w[47:32];
    ra = w[63:48];
    want = w[95:64];
    mode = w[97:96];
    tgt = w[99:98];
    size = pool_size_reg > DEPTH ? DEPTH : pool_size_reg;
    if (!((mode == dlpa_pkg::MODE_DISCOVER && tgt == dlpa_pkg::TGT_BCAST) ||
          (mode == dlpa_pkg::MODE_REQUEST &&
           (tgt == dlpa_pkg::TGT_HERE || tgt == dlpa_pkg::TGT_OTHER)))) return;
    // Expiry sweep before the message is handled
    for (int a = 0; a < size; a++) begin
      if (lease_exp[a] > {1'b0, now}) continue;
      if (lease_st[a] == dlpa_pkg::ST_OFFER) begin
        lease_st[a] = dlpa_pkg::ST_FREE;
        lease_owner[a] = '0;
        lease_exp[a] = '0;
      end else if (lease_st[a] == dlpa_pkg::ST_OCC) begin
        lease_st[a] = dlpa_pkg::ST_EXP;
        lease_exp[a] = '0;
      end
    end
    if (mode == dlpa_pkg::MODE_DISCOVER) begin
      pick = -1;
      for (int a = 0; a < size && pick < 0; a++)
        if (lease_st[a] != dlpa_pkg::ST_FREE && lease_owner[a] == cl) pick = a;
      for (int a = 0; a < size && pick < 0; a++)
        if (lease_st[a] == dlpa_pkg::ST_FREE) pick = a;
      for (int a = 0; a < size && pick < 0; a++)
        if (lease_st[a] == dlpa_pkg::ST_EXP) pick = a;
      if (pick < 0) return;
      lease_st[pick] = dlpa_pkg::ST_OFFER;
      lease_owner[pick] = cl;
      lease_exp[pick] = lease_end(now, want);
      last_offer[cl] = dlpa_pkg::ADDR_W'(pick + 1);
      r = '{dlpa_pkg::KIND_OFFER, cl, dlpa_pkg::ADDR_W'(pick + 1), lease_exp[pick]};
      replies_due.push_back(r);
    end else if (tgt == dlpa_pkg::TGT_OTHER) begin
      for (int a = 0; a < size; a++)
        if (lease_st[a] == dlpa_pkg::ST_OFFER && lease_owner[a] == cl) begin
          lease_st[a] = dlpa_pkg::ST_FREE;
          lease_owner[a] = '0;
          lease_exp[a] = '0;
        end
    end else begin
      r = '{dlpa_pkg::KIND_NAK, cl, ra, '0};
      if (ra >= 1 && ra <= size && lease_st[ra-1] != dlpa_pkg::ST_FREE &&
          lease_owner[ra-1] == cl) begin
        lease_st[ra-1] = dlpa_pkg::ST_OCC;
        lease_exp[ra-1] = lease_end(now, want);
        r.kind = dlpa_pkg::KIND_ACK;
        r.expiry = lease_exp[ra-1];
      end
      replies_due.push_back(r);
    end
  endfunction

  // Message driver: one word at a time from the pending queue, random gaps between words while gaps are on.
  always @(posedge clk) begin
    logic       nv;
    logic [99:0] w;
    if (!rst) begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        serve_message({s_tuser, s_tdata});
        msgs_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) send_gap--;
        else if (msgs_pending.size() > 0) begin
          w = msgs_pending.pop_front();
          s_tdata <= w[95:0];
          s_tuser <= w[99:96];
          nv = 1'b1;
          send_gap = gaps_on ? $urandom_range(0, 19) : 0;
        end
      end
      s_tvalid <= nv;
    end
  end

  // Reply monitor: check each accepted word, stall the ready at random while gaps are on.
  always @(posedge clk) begin
    reply_t r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) report("reply with none expected");
        else begin
          r = replies_due.pop_front();
          if (m_tuser != r.kind) report($sformatf("kind %0d, want %0d", m_tuser, r.kind));
          if (m_tdata[15:0] != r.client)
            report($sformatf("client %h, want %h", m_tdata[15:0], r.client));
          if (m_tdata[31:16] != r.addr)
            report($sformatf("addr %h, want %h", m_tdata[31:16], r.addr));
          if (m_tdata[64:32] != r.expiry)
            report($sformatf("expiry %h, want %h", m_tdata[64:32], r.expiry));
          if (m_tdata[71:65] != '0) report("fill bits not zero");
        end
        recv_stall = gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("dhcp_lease_pool_allocator_top_test NOT OK");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      dlpa_pkg::CFG_POOL_SIZE: pool_size_reg = v[dlpa_pkg::SIZE_W-1:0];
      dlpa_pkg::CFG_DEF_LEASE: def_lease_reg = v;
      dlpa_pkg::CFG_MAX_LEASE: max_lease_reg = v;
      default:                 min_lease_reg = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every reply is in and the block has finished any silent messages.
  task automatic settle();
    while (msgs_taken != msgs_queued || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(input int psz, input logic [31:0] dl, mx, mn);
    settle();
    write_reg(dlpa_pkg::CFG_POOL_SIZE, 32'(psz));
    write_reg(dlpa_pkg::CFG_DEF_LEASE, dl);
    write_reg(dlpa_pkg::CFG_MAX_LEASE, mx);
    write_reg(dlpa_pkg::CFG_MIN_LEASE, mn);
  endtask

  // Queue one message and wait until it is taken, so the mirror is current.
  task automatic send(input logic [15:0] cl, input logic [1:0] mode, tgt,
                      input logic [15:0] ra, input logic [31:0] want);
    msgs_pending.push_back({tgt, mode, want, ra, cl, clock_now});
    msgs_queued++;
    while (msgs_taken != msgs_queued) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [15:0] cl, ra;
    logic [31:0] want;
    int          pick;
    gaps_on = $urandom_range(0, 3) != 0;
    for (int i = 0; i < count; i++) begin
      clock_now += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      cl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       want = 0;
        1:       want = $urandom;
        default: want = clock_now + $urandom_range(0, 600) - 100;
      endcase
      pick = $urandom_range(0, 99);
      ra = last_offer.exists(cl) ? last_offer[cl] : 16'($urandom_range(1, 8));
      if (pick < 40)
        send(cl, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 16'($urandom), want);
      else if (pick < 70) send(cl, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, ra, want);
      else if (pick < 80)
        send(cl, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 16'($urandom), want);
      else if (pick < 90)
        send(cl, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_OTHER, 16'($urandom), want);
      else begin
        // Ignored combinations, not counted
        send(cl, 2'($urandom_range(2, 3)), 2'($urandom_range(0, 3)), ra, want);
        i--;
      end
    end
  endtask

  initial begin
    for (int a = 0; a < DEPTH; a++) begin
      lease_st[a] = dlpa_pkg::ST_FREE;
      lease_owner[a] = '0;
      lease_exp[a] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a tiny pool
    setup(3, 100, 500, 50);
    send(16'h0000, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0000, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 1, 32'hFFFF_FFFF);
    send(16'hFFFF, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 16'hFFFF, 5);
    send(16'hFFFF, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_OTHER, 0, 0);
    clock_now = 10;
    send(16'h0001, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 210);
    send(16'h0002, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0003, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0003, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 0, 0);
    send(16'h0003, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 16'hFFFF, 0);
    send(16'h0003, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 4, 0);
    send(16'h0003, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 2, 0);
    send(16'h0001, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 2, 300);
    send(16'h0003, 2'd2, dlpa_pkg::TGT_BCAST, 1, 0);
    send(16'h0003, 2'd3, 2'd3, 1, 0);
    send(16'h0003, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_HERE, 1, 0);
    send(16'h0003, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_BCAST, 1, 0);
    clock_now = 1000;
    send(16'h0005, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0000, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0006, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0007, dlpa_pkg::MODE_DISCOVER, dlpa_pkg::TGT_BCAST, 0, 0);
    send(16'h0000, dlpa_pkg::MODE_REQUEST, dlpa_pkg::TGT_HERE, 1, 32'h0000_FFFF);

    // Random phases over several register settings
    setup(8, 100, 400, 20);
    random_phase(50);
    setup(1, 0, 0, 0);
    random_phase(25);
    setup(0, 50, 100, 10);
    random_phase(15);
    setup(16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    random_phase(30);
    setup(5, 50, 30, 200);
    random_phase(50);
    setup(2047, 80, 300, 30);
    random_phase(8);
    setup(1024, 200, 600, 0);
    random_phase(8);
    setup(6, 150, 500, 40);
    random_phase(30);
    clock_now = 32'hFFFF_0000;
    random_phase(30);

    settle();
    if (errors == 0) $display("dhcp_lease_pool_allocator_top_test OK");
    else $display("dhcp_lease_pool_allocator_top_test NOT OK");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/dlpa_pkg.sv
design/dlpa_ram.sv
design/dlpa_front.sv
design/dlpa_queue.sv
design/dlpa_back.sv
design/dhcp_lease_pool_allocator_top.sv
tb/dhcp_lease_pool_allocator_top_test.sv
